// ----- hw/rtl/mfo_pkg.sv -----
// Shared types, angle constants and fixed-point helpers of the oscillator integrator
package mfo_pkg;

   // multiplier operand and product
   typedef logic signed [32:0] mop_type;
   typedef logic signed [65:0] mprod_type;

   // angles in Q32, gain in Q30
   localparam logic [63:0] PI_Q32      = 64'd13493037705;
   localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
   localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
   localparam logic [63:0] GAIN_Q30    = 64'd652032874;

   localparam int ATAN_DEPTH = 30;

   // arctan(2^-i) in Q30, truncated but for the last three entries, which are rounded up
   localparam logic [29:0] ATAN_Q30 [ATAN_DEPTH] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
      30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
      30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
      30'd31, 30'd15, 30'd8, 30'd4, 30'd2
   };

   // Q32 -> Q.frac, round half up
   function automatic logic [63:0] q32_frac(input logic [63:0] q, input int frac);
      return ((q >> (31 - frac)) + 64'd1) >> 1;
   endfunction

   // Q30 -> Q.frac, round half up (non-negative inputs)
   function automatic logic [63:0] q30_frac(input logic [63:0] q, input int frac);
      logic [63:0] half;
      half = (frac == 30) ? 64'd0 : (64'd1 << (29 - frac));
      return (q + half) >> (30 - frac);
   endfunction

endpackage

// ----- hw/rtl/mean_field_oscillator_euler_unit.sv -----
// Top level of the forward-Euler adaptive oscillator integrator
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  req     | in        | req_tvalid / req_tready | tuser: kind; tdata: phase, freq, time
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata: phase, freq, time
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_wdata (always ready)
//
// A run transaction performs steps_per_save Euler steps (none if it is zero) and then
// advances time by save_dt; the modulo-2pi unit (reciprocal estimate per 16-bit chunk)
// and the iterative CORDIC, each used twice per step, set its length.
// req_tready is high only while idle; a finished result waits in the rsp
// register and the next request is taken while it waits.
// reset is synchronous: state and time clear to zero, registers to their defaults.
module mean_field_oscillator_euler_unit #(
   parameter int FRAC_BITS    = 24,
   parameter int CORDIC_ITERS = 24
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // [31:0] phase_in, [63:32] freq_in, [111:64] time_in
   input  logic         req_tuser,   // [0] kind: 0 load, 1 run
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [31:0] phase_out, [63:32] freq_out, [111:64] time_out
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int REM_W = FRAC_BITS + 3;   // holds 2pi
   localparam int CW    = FRAC_BITS + 4;   // CORDIC datapath
   localparam int MOD_W = 81 - FRAC_BITS;  // |omega*s| >> FRAC_BITS
   localparam logic [REM_W-1:0] TP_V =
      REM_W'(mfo_pkg::q32_frac(mfo_pkg::TWO_PI_Q32, FRAC_BITS));
   localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [49:0] T48_MAX = 50'sd140737488355327;

   localparam logic [30:0] STEP_DT_RST = 31'd16777;
   localparam logic [30:0] SAVE_DT_RST = 31'd167772;
   localparam logic [15:0] STEPS_RST   = 16'd10;

   // register indexes
   localparam logic [2:0] CSR_K_GAIN   = 3'd0;
   localparam logic [2:0] CSR_LAMBDA   = 3'd1;
   localparam logic [2:0] CSR_OMEGA_F  = 3'd2;
   localparam logic [2:0] CSR_STEP_DT  = 3'd3;
   localparam logic [2:0] CSR_SAVE_DT  = 3'd4;
   localparam logic [2:0] CSR_STEPS    = 3'd5;

   localparam logic KIND_LOAD = 1'b0;

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_PM_GO   = 5'd1;   // phase mod 2pi
   localparam logic [4:0] ST_PM_WAIT = 5'd2;
   localparam logic [4:0] ST_PC_GO   = 5'd3;   // sin(phase)
   localparam logic [4:0] ST_PC_WAIT = 5'd4;
   localparam logic [4:0] ST_FM_LO   = 5'd5;   // |omega| * |s|, two partial products
   localparam logic [4:0] ST_FM_HI   = 5'd6;
   localparam logic [4:0] ST_FD_GO   = 5'd7;   // forcing angle mod 2pi
   localparam logic [4:0] ST_FD_WAIT = 5'd8;
   localparam logic [4:0] ST_FC_GO   = 5'd9;   // cos(forcing)
   localparam logic [4:0] ST_FC_WAIT = 5'd10;
   localparam logic [4:0] ST_MK      = 5'd11;  // k * sin
   localparam logic [4:0] ST_MC      = 5'd12;  // * cos
   localparam logic [4:0] ST_ML      = 5'd13;  // tt; lambda * freq
   localparam logic [4:0] ST_MD      = 5'd14;  // d0
   localparam logic [4:0] ST_MP      = 5'd15;  // d0 * dt
   localparam logic [4:0] ST_MF      = 5'd16;  // new phase; tt * dt
   localparam logic [4:0] ST_MU      = 5'd17;  // commit step
   localparam logic [4:0] ST_TIME    = 5'd18;
   localparam logic [4:0] ST_OUT     = 5'd19;

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      if (v > 70'sd2147483647)
         return 32'sh7FFF_FFFF;
      else if (v < -70'sd2147483648)
         return 32'sh8000_0000;
      else
         return 32'(v);
   endfunction

   logic [4:0]         state_ff, state_in;
   logic signed [31:0] phase_ff, phase_in, freq_ff, freq_in;
   logic signed [47:0] time_ff, time_in;
   logic signed [31:0] k_ff, k_in, lam_ff, lam_in, omega_ff, omega_in;
   logic [30:0]        step_dt_ff, step_dt_in, save_dt_ff, save_dt_in;
   logic [15:0]        steps_ff, steps_in;
   logic signed [49:0] s_ff, s_in;               // time + j*step_dt
   logic [15:0]        j_ff, j_in;
   logic [63:0]        lo_ff, lo_in;
   mfo_pkg::mop_type   sp_ff, sp_in, cf_ff, cf_in;
   logic signed [31:0] tt_ff, tt_in, d0_ff, d0_in, pnew_ff, pnew_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [111:0]       rsp_data_ff, rsp_data_in;

   mfo_pkg::mop_type   mul_a, mul_b;
   mfo_pkg::mprod_type prod, prod_sh;
   logic               mod_start, mod_done;
   logic [MOD_W-1:0]   mod_div;
   logic [REM_W-1:0]   mod_rem;
   logic               cor_start, cor_done;
   logic [REM_W-1:0]   cor_angle;
   logic signed [CW-1:0] cor_sin, cor_cos;

   logic [31:0]        phase_abs, omega_abs;
   logic [48:0]        s_abs;
   logic [80:0]        fsum;
   logic signed [49:0] tsum;

   mfo_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   mfo_mod #(
      .DIV_W   (MOD_W),
      .REM_W   (REM_W),
      .MODULUS (TP_V)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   mfo_cordic #(
      .FRAC_BITS (FRAC_BITS),
      .ITERS     (CORDIC_ITERS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      prod_sh   = prod >>> FRAC_BITS;
      phase_abs = phase_ff[31] ? 32'(-phase_ff) : 32'(phase_ff);
      omega_abs = omega_ff[31] ? 32'(-omega_ff) : 32'(omega_ff);
      s_abs     = s_ff[49] ? 49'(-s_ff) : 49'(s_ff);
      fsum      = 81'(lo_ff) + {prod[48:0], 32'b0};
      tsum      = 50'(time_ff) + $signed({19'b0, save_dt_ff});

      state_in   = state_ff;
      phase_in   = phase_ff;
      freq_in    = freq_ff;
      time_in    = time_ff;
      k_in       = k_ff;
      lam_in     = lam_ff;
      omega_in   = omega_ff;
      step_dt_in = step_dt_ff;
      save_dt_in = save_dt_ff;
      steps_in   = steps_ff;
      s_in       = s_ff;
      j_in       = j_ff;
      lo_in      = lo_ff;
      sp_in      = sp_ff;
      cf_in      = cf_ff;
      tt_in      = tt_ff;
      d0_in      = d0_ff;
      pnew_in    = pnew_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mul_a     = '0;
      mul_b     = '0;
      mod_start = 1'b0;
      mod_div   = MOD_W'(phase_abs);
      cor_start = 1'b0;
      cor_angle = mod_rem;

      // register writes are taken in any state; the host writes only while idle
      if (csr_valid) begin
         case (csr_index)
            CSR_K_GAIN:  k_in       = csr_wdata;
            CSR_LAMBDA:  lam_in     = csr_wdata;
            CSR_OMEGA_F: omega_in   = csr_wdata;
            CSR_STEP_DT: step_dt_in = csr_wdata[30:0];
            CSR_SAVE_DT: save_dt_in = csr_wdata[30:0];
            CSR_STEPS:   steps_in   = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == KIND_LOAD) begin
                  phase_in = req_tdata[31:0];
                  freq_in  = req_tdata[63:32];
                  time_in  = req_tdata[111:64];
                  state_in = ST_OUT;
               end else begin
                  s_in     = 50'(time_ff);
                  j_in     = '0;
                  state_in = (steps_ff == 16'd0) ? ST_TIME : ST_PM_GO;
               end
            end
         end
         ST_PM_GO: begin
            mod_start = 1'b1;
            state_in  = ST_PM_WAIT;
         end
         ST_PM_WAIT: begin
            if (mod_done) state_in = ST_PC_GO;
         end
         ST_PC_GO: begin
            // truncating remainder of a negative phase, made non-negative
            cor_start = 1'b1;
            cor_angle = (phase_ff[31] && mod_rem != '0) ? TP_V - mod_rem : mod_rem;
            state_in  = ST_PC_WAIT;
         end
         ST_PC_WAIT: begin
            if (cor_done) begin
               sp_in    = 33'(cor_sin);
               state_in = ST_FM_LO;
            end
         end
         ST_FM_LO: begin
            mul_a    = $signed({1'b0, omega_abs});
            mul_b    = $signed({1'b0, s_abs[31:0]});
            state_in = ST_FM_HI;
         end
         ST_FM_HI: begin
            lo_in    = prod[63:0];
            mul_a    = $signed({1'b0, omega_abs});
            mul_b    = $signed({16'b0, s_abs[48:32]});
            state_in = ST_FD_GO;
         end
         ST_FD_GO: begin
            mod_start = 1'b1;
            mod_div   = MOD_W'(fsum >> FRAC_BITS);
            state_in  = ST_FD_WAIT;
         end
         ST_FD_WAIT: begin
            if (mod_done) state_in = ST_FC_GO;
         end
         ST_FC_GO: begin
            cor_start = 1'b1;
            state_in  = ST_FC_WAIT;
         end
         ST_FC_WAIT: begin
            if (cor_done) begin
               cf_in    = 33'(cor_cos);
               state_in = ST_MK;
            end
         end
         ST_MK: begin
            mul_a    = 33'(k_ff);
            mul_b    = sp_ff;
            state_in = ST_MC;
         end
         ST_MC: begin
            mul_a    = 33'(prod_sh);
            mul_b    = cf_ff;
            state_in = ST_ML;
         end
         ST_ML: begin
            tt_in    = sat32(-(70'(prod_sh)));
            mul_a    = 33'(lam_ff);
            mul_b    = 33'(freq_ff);
            state_in = ST_MD;
         end
         ST_MD: begin
            d0_in    = sat32(70'(prod_sh) + 70'(tt_ff));
            state_in = ST_MP;
         end
         ST_MP: begin
            mul_a    = 33'(d0_ff);
            mul_b    = $signed({2'b0, step_dt_ff});
            state_in = ST_MF;
         end
         ST_MF: begin
            pnew_in  = sat32(70'(phase_ff) + 70'(prod_sh));
            mul_a    = 33'(tt_ff);
            mul_b    = $signed({2'b0, step_dt_ff});
            state_in = ST_MU;
         end
         ST_MU: begin
            phase_in = pnew_ff;
            freq_in  = sat32(70'(freq_ff) + 70'(prod_sh));
            s_in     = s_ff + $signed({19'b0, step_dt_ff});
            j_in     = j_ff + 16'd1;
            state_in = (j_ff + 16'd1 == steps_ff) ? ST_TIME : ST_PM_GO;
         end
         ST_TIME: begin
            time_in  = (tsum > T48_MAX) ? 48'(T48_MAX) : 48'(tsum);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {time_ff, freq_ff, phase_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         freq_ff      <= '0;
         time_ff      <= '0;
         k_ff         <= ONE;
         lam_ff       <= ONE;
         omega_ff     <= ONE;
         step_dt_ff   <= STEP_DT_RST;
         save_dt_ff   <= SAVE_DT_RST;
         steps_ff     <= STEPS_RST;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         freq_ff      <= freq_in;
         time_ff      <= time_in;
         k_ff         <= k_in;
         lam_ff       <= lam_in;
         omega_ff     <= omega_in;
         step_dt_ff   <= step_dt_in;
         save_dt_ff   <= save_dt_in;
         steps_ff     <= steps_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff        <= s_in;
      lo_ff       <= lo_in;
      sp_ff       <= sp_in;
      cf_ff       <= cf_in;
      tt_ff       <= tt_in;
      d0_ff       <= d0_in;
      pnew_ff     <= pnew_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/mfo_mul.sv -----
// Shared signed multiplier with registered product
module mfo_mul (
   input  logic                clock,
   input  mfo_pkg::mop_type    op_a,
   input  mfo_pkg::mop_type    op_b,
   output mfo_pkg::mprod_type  prod
);

   mfo_pkg::mprod_type prod_ff;
   mfo_pkg::mprod_type prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/mfo_mod.sv -----
// Remainder of a wide unsigned value by a constant modulus, by reciprocal estimate per chunk
module mfo_mod #(
   parameter int DIV_W = 57,
   parameter int REM_W = 27,
   parameter logic [REM_W-1:0] MODULUS = 105414357
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             done,
   output logic [REM_W-1:0] remainder
);

   // 16 dividend bits per chunk:
   // first estimate the chunk quotient from the top 32 bits, then subtract and correct once
   localparam int CH    = 16;
   localparam int NCH   = (DIV_W + CH - 1) / CH;
   localparam int PAD_W = NCH * CH;
   localparam int TW    = REM_W + CH;
   localparam int SH_U  = TW - 32;
   localparam int QSH   = 36;
   localparam int RW    = CH + 5;
   localparam int EW    = 32 + RW;
   localparam logic [RW-1:0] RECIP = RW'((64'd1 << (SH_U + QSH)) / 64'(MODULUS));
   localparam int CNT_W = $clog2(NCH + 1);

   logic             busy_ff, busy_in;
   logic             half_ff, half_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAD_W-1:0] div_ff, div_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [TW-1:0]    t_ff, t_in;
   logic [CH-1:0]    q_ff, q_in;
   logic [TW-1:0]    t_cur;
   logic [EW-1:0]    est;
   logic [TW-1:0]    r_est;
   logic [TW-1:0]    r_sub;

   always_comb begin
      t_cur   = {rem_ff, div_ff[PAD_W-1 -: CH]};
      est     = EW'(t_cur[TW-1:SH_U]) * EW'(RECIP);
      r_est   = t_ff - TW'(q_ff) * TW'(MODULUS);
      r_sub   = r_est - TW'(MODULUS);
      busy_in = busy_ff;
      half_in = half_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      t_in    = t_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         half_in = 1'b0;
         cnt_in  = CNT_W'(NCH);
         div_in  = PAD_W'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!half_ff) begin
            // estimate never exceeds the true quotient, and falls short by at most one
            q_in    = est[QSH +: CH];
            t_in    = t_cur;
            div_in  = div_ff << CH;
            half_in = 1'b1;
         end else begin
            rem_in  = (r_est >= TW'(MODULUS)) ? REM_W'(r_sub) : REM_W'(r_est);
            half_in = 1'b0;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         half_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         half_ff <= half_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      t_ff   <= t_in;
      q_ff   <= q_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/mfo_cordic.sv -----
// Iterative rotation CORDIC: angle in [0, 2pi) to sine and cosine
module mfo_cordic #(
   parameter int FRAC_BITS = 24,
   parameter int ITERS     = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [FRAC_BITS+2:0]        angle,
   output logic                        done,
   output logic signed [FRAC_BITS+3:0] sin_out,
   output logic signed [FRAC_BITS+3:0] cos_out
);

   localparam int CW = FRAC_BITS + 4;
   localparam int SH = 30 - FRAC_BITS;
   localparam logic [63:0] HALF = (SH == 0) ? 64'd0 : (64'd1 << (SH - 1));
   localparam logic signed [CW-1:0] PI_V =
      CW'(mfo_pkg::q32_frac(mfo_pkg::PI_Q32, FRAC_BITS));
   localparam logic signed [CW-1:0] HP_V =
      CW'(mfo_pkg::q32_frac(mfo_pkg::HALF_PI_Q32, FRAC_BITS));
   localparam logic signed [CW-1:0] TP_V =
      CW'(mfo_pkg::q32_frac(mfo_pkg::TWO_PI_Q32, FRAC_BITS));
   localparam logic signed [CW-1:0] GAIN_V =
      CW'(mfo_pkg::q30_frac(mfo_pkg::GAIN_Q30, FRAC_BITS));

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           idx_ff, idx_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CW-1:0] a0, a1, xs, ys, at;

   always_comb begin
      a0      = $signed({1'b0, angle});
      a1      = (a0 > PI_V) ? a0 - TP_V : a0;
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = CW'((64'(mfo_pkg::ATAN_Q30[idx_ff]) + HALF) >> SH);
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         // fold into [-pi/2, pi/2], flip signs of the result
         busy_in = 1'b1;
         idx_in  = '0;
         x_in    = GAIN_V;
         y_in    = '0;
         if (a1 > HP_V) begin
            z_in   = a1 - PI_V;
            neg_in = 1'b1;
         end else if (a1 < -HP_V) begin
            z_in   = a1 + PI_V;
            neg_in = 1'b1;
         end else begin
            z_in   = a1;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         idx_in = idx_ff + 5'd1;
         if (idx_ff == 5'(ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = done_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;

endmodule

// ----- tb/tb_mean_field_oscillator_euler_unit.sv -----
// Testbench of the forward-Euler adaptive oscillator unit: directed and random checks
module tb_mean_field_oscillator_euler_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC  = 24;
   localparam int ITERS = 24;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 20;

   // register indexes
   localparam logic [2:0] REG_K_GAIN      = 3'd0;
   localparam logic [2:0] REG_LAMBDA_GAIN = 3'd1;
   localparam logic [2:0] REG_OMEGA_F     = 3'd2;
   localparam logic [2:0] REG_STEP_DT     = 3'd3;
   localparam logic [2:0] REG_SAVE_DT     = 3'd4;
   localparam logic [2:0] REG_STEPS       = 3'd5;
   localparam logic [2:0] REG_UNUSED      = 3'd6;

   // transaction kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   localparam longint T48_HI = 64'sd140737488355327;
   localparam longint T48_LO = -64'sd140737488355328;

   typedef struct {
      logic               kind;
      logic signed [31:0] phase;
      logic signed [31:0] freq;
      logic signed [47:0] tstamp;
   } osc_item_type;

   typedef struct {
      logic signed [31:0] phase;
      logic signed [31:0] freq;
      logic signed [47:0] tstamp;
   } osc_sample_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   osc_item_type   pending_items[$];
   osc_sample_type expected_samples[$];
   int          idle_pct = 21;
   int          mismatches = 0;
   longint      cycle_count = 0;

   // local copy of the oscillator state and registers
   longint osc_phase, osc_freq, osc_time;
   longint gain_k, gain_lambda, omega, dt_step, dt_save, n_steps;

   mean_field_oscillator_euler_unit #(
      .FRAC_BITS(FRAC),
      .CORDIC_ITERS(ITERS)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q32 constant -> Q.FRAC, round half up
   function automatic longint angle_const(logic [63:0] q);
      return longint'(((q >> (31 - FRAC)) + 64'd1) >> 1);
   endfunction

   // rotation CORDIC on an angle in [0, 2pi)
   function automatic void cordic_sincos(longint ang, output longint sn, output longint cs);
      longint pi_c, hp_c, tp_c, x, y, z, nx, at;
      bit flip;
      pi_c = angle_const(mfo_pkg::PI_Q32);
      hp_c = angle_const(mfo_pkg::HALF_PI_Q32);
      tp_c = angle_const(mfo_pkg::TWO_PI_Q32);
      x = (longint'(mfo_pkg::GAIN_Q30) + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      y = 0;
      flip = 1'b0;
      if (ang > pi_c) ang -= tp_c;
      if (ang > hp_c) begin
         ang -= pi_c;
         flip = 1'b1;
      end else if (ang < -hp_c) begin
         ang += pi_c;
         flip = 1'b1;
      end
      z = ang;
      for (int i = 0; i < ITERS && i < mfo_pkg::ATAN_DEPTH; i++) begin
         at = (longint'(mfo_pkg::ATAN_Q30[i]) + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= at;
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += at;
         end
         x = nx;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   // |omega * t| >> FRAC modulo 2pi, with a full-width product
   function automatic longint forcing_phase(longint t);
      logic [63:0]  a, mt, ang;
      logic [127:0] prod;
      a    = (omega < 0) ? 64'(-omega) : 64'(omega);
      mt   = (t < 0) ? 64'(-t) : 64'(t);
      prod = 128'(a) * 128'(mt);
      ang  = prod[FRAC +: 64];
      return longint'(ang % 64'(angle_const(mfo_pkg::TWO_PI_Q32)));
   endfunction

   // advance the local oscillator state by one accepted transaction
   function automatic osc_sample_type integrate_item(osc_item_type it);
      osc_sample_type r;
      longint tp_c, pa, sp, cp, sf, cf, m, tt, d0;
      tp_c = angle_const(mfo_pkg::TWO_PI_Q32);
      if (it.kind == KIND_LOAD) begin
         osc_phase = it.phase;
         osc_freq  = it.freq;
         osc_time  = it.tstamp;
      end else begin
         for (longint j = 0; j < n_steps; j++) begin
            pa = osc_phase % tp_c;
            if (pa < 0) pa += tp_c;
            cordic_sincos(pa, sp, cp);
            cordic_sincos(forcing_phase(osc_time + j * dt_step), sf, cf);
            m  = (gain_k * sp) >>> FRAC;
            m  = (m * cf) >>> FRAC;
            tt = sat_word(-m);
            d0 = sat_word(((gain_lambda * osc_freq) >>> FRAC) + tt);
            osc_phase = sat_word(osc_phase + ((d0 * dt_step) >>> FRAC));
            osc_freq  = sat_word(osc_freq + ((tt * dt_step) >>> FRAC));
         end
         osc_time += dt_save;
         if (osc_time > T48_HI) osc_time = T48_HI;
         if (osc_time < T48_LO) osc_time = T48_LO;
      end
      r.phase  = osc_phase[31:0];
      r.freq   = osc_freq[31:0];
      r.tstamp = osc_time[47:0];
      return r;
   endfunction

   // request driver: predicts on every accepted transaction
   always @(posedge clock) begin
      osc_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            it.kind   = req_tuser;
            it.phase  = req_tdata[31:0];
            it.freq   = req_tdata[63:32];
            it.tstamp = req_tdata[111:64];
            expected_samples.push_back(integrate_item(it));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
               it = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= it.kind;
               req_tdata  <= {it.tstamp, it.freq, it.phase};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      osc_sample_type want;
      logic signed [31:0] got_ph, got_fr;
      logic signed [47:0] got_t;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got_ph = rsp_tdata[31:0];
            got_fr = rsp_tdata[63:32];
            got_t  = rsp_tdata[111:64];
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transaction: phase %0d freq %0d t %0d",
                           got_ph, got_fr, got_t);
            end else begin
               want = expected_samples.pop_front();
               if (got_ph !== want.phase || got_fr !== want.freq || got_t !== want.tstamp) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp phase %0d freq %0d t %0d, got %0d %0d %0d",
                              want.phase, want.freq, want.tstamp, got_ph, got_fr, got_t);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_K_GAIN:      gain_k      = longint'(signed'(val));
         REG_LAMBDA_GAIN: gain_lambda = longint'(signed'(val));
         REG_OMEGA_F:     omega       = longint'(signed'(val));
         REG_STEP_DT:     dt_step     = longint'(val[30:0]);
         REG_SAVE_DT:     dt_save     = longint'(val[30:0]);
         REG_STEPS:       n_steps     = longint'(val[15:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [31:0] k, logic [31:0] lam, logic [31:0] w,
                            logic [31:0] sdt, logic [31:0] svdt, logic [31:0] ns);
      write_reg(REG_K_GAIN, k);
      write_reg(REG_LAMBDA_GAIN, lam);
      write_reg(REG_OMEGA_F, w);
      write_reg(REG_STEP_DT, sdt);
      write_reg(REG_SAVE_DT, svdt);
      write_reg(REG_STEPS, ns);
   endtask

   // waits until every queued item is sent and every result is back, then lets the bench drain
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_item(logic kind, logic [31:0] ph, logic [31:0] fr, logic [47:0] t);
      osc_item_type it;
      it.kind = kind;
      it.phase = ph;
      it.freq = fr;
      it.tstamp = t;
      pending_items.push_back(it);
   endtask

   // mostly runs, else loads (only loads if loads_only), either full-range or near-physical
   task automatic add_random(int n, bit loads_only);
      logic [31:0] ph, fr;
      logic [47:0] t;
      for (int i = 0; i < n; i++) begin
         if (loads_only || $urandom_range(99) < 30) begin
            if ($urandom_range(1)) begin
               ph = $urandom;
               fr = $urandom;
               t  = 48'({$urandom, $urandom});
            end else begin
               ph = 32'($signed($urandom_range(32'h0FFFFFFF)) - 32'sh08000000);
               fr = 32'($signed($urandom_range(32'h07FFFFFF)) - 32'sh04000000);
               t  = 48'($urandom_range(32'h7FFFFFFF));
            end
            add_item(KIND_LOAD, ph, fr, t);
         end else begin
            add_item(KIND_RUN, $urandom, $urandom, 48'({$urandom, $urandom}));
         end
      end
   endtask

   function automatic logic [31:0] rand_gain();
      return 32'($signed($urandom_range(32'h07FFFFFF)) - 32'sh04000000);
   endfunction

   initial begin
      osc_phase = 0; osc_freq = 0; osc_time = 0;
      gain_k = 16777216; gain_lambda = 16777216; omega = 16777216;
      dt_step = 16777; dt_save = 167772; n_steps = 10;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      add_item(KIND_RUN, '0, '0, '0);
      add_item(KIND_LOAD, 32'h7FFFFFFF, 32'h80000000, 48'h7FFFFFFFFFFF);
      add_item(KIND_LOAD, 32'h80000000, 32'h7FFFFFFF, 48'h800000000000);
      add_item(KIND_RUN, '0, '0, '0);
      add_item(KIND_LOAD, 32'h01000000, 32'h00800000, 48'h0);
      add_item(KIND_RUN, '0, '0, '0);
      add_item(KIND_RUN, '0, '0, '0);
      // time saturates at the top
      add_item(KIND_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'h7FFFFFFFFFF0);
      add_item(KIND_RUN, '0, '0, '0);
      add_item(KIND_LOAD, 32'hF0000000, 32'hFF000000, 48'hFFFFFF000000);
      add_item(KIND_RUN, '0, '0, '0);
      wait_quiet();

      // moderate random registers, out-of-range index is ignored
      write_all(rand_gain(), rand_gain(), rand_gain(), $urandom_range(1, 1 << 22),
                $urandom_range(1, 1 << 24), 3);
      write_reg(REG_UNUSED, $urandom);
      add_random(110, 1'b0);
      wait_quiet();

      // extremes: saturation everywhere
      write_all(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 2);
      add_item(KIND_LOAD, 32'h7FFFFFFF, 32'h80000000, 48'h7FFFFFFFFFFF);
      add_item(KIND_RUN, '0, '0, '0);
      add_random(90, 1'b0);
      wait_quiet();

      // other extremes, no idling at all in this stretch
      idle_pct = 0;
      write_all(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1);
      add_random(100, 1'b0);
      wait_quiet();
      idle_pct = 21;

      // zero steps: only time moves
      write_reg(REG_STEPS, 0);
      add_random(50, 1'b0);
      wait_quiet();

      // widest step count, loads only to keep run time bounded
      write_reg(REG_STEPS, 32'h0000FFFF);
      add_random(20, 1'b1);
      wait_quiet();

      // random registers per phase
      for (int p = 0; p < 6; p++) begin
         write_all(($urandom_range(3) == 0) ? $urandom : rand_gain(),
                   ($urandom_range(3) == 0) ? $urandom : rand_gain(),
                   ($urandom_range(3) == 0) ? $urandom : rand_gain(),
                   $urandom_range(1, 1 << 23), $urandom_range(1, 1 << 26),
                   $urandom_range(1, 4));
         add_random(45, 1'b0);
         wait_quiet();
      end

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ----- mean_field_oscillator_euler_unit.f -----
hw/rtl/mfo_pkg.sv
hw/rtl/mfo_mul.sv
hw/rtl/mfo_mod.sv
hw/rtl/mfo_cordic.sv
hw/rtl/mean_field_oscillator_euler_unit.sv
tb/tb_mean_field_oscillator_euler_unit.sv
